### rtl/cfmc_pkg.sv
// Shared types, constants and coefficient tables for the color matrix composer.
`default_nettype none
package cfmc_pkg;

  localparam int COEF_W = 32;
  localparam int FRAC   = 16;
  localparam int ACC_W  = 68;

  localparam logic [2:0] MODE_IDENT    = 3'd0;
  localparam logic [2:0] MODE_GRAY     = 3'd1;
  localparam logic [2:0] MODE_BRIGHT   = 3'd2;
  localparam logic [2:0] MODE_CONTRAST = 3'd3;
  localparam logic [2:0] MODE_SAT      = 3'd4;
  localparam logic [2:0] MODE_HUE      = 3'd5;

  localparam logic [1:0] SET_GRAY = 2'd0;
  localparam logic [1:0] SET_SAT  = 2'd1;
  localparam logic [1:0] SET_HUE  = 2'd2;

  typedef logic signed [COEF_W-1:0] coef_t;

  localparam coef_t ONE = coef_t'(64'sd1 <<< FRAC);

  // Q30 constants
  localparam coef_t Q30_ONE = 32'sd1073741824;
  localparam coef_t K2126 = 32'sd228277512;
  localparam coef_t K7874 = 32'sd845464312;
  localparam coef_t K7152 = 32'sd767940153;
  localparam coef_t K2848 = 32'sd305801671;
  localparam coef_t K213  = 32'sd228707009;
  localparam coef_t K787  = 32'sd845034815;
  localparam coef_t K715  = 32'sd767725404;
  localparam coef_t K285  = 32'sd306016420;
  localparam coef_t K072  = 32'sd77309411;
  localparam coef_t K928  = 32'sd996432413;
  localparam coef_t K143  = 32'sd153545081;
  localparam coef_t K140  = 32'sd150323855;
  localparam coef_t K283  = 32'sd303868936;
  localparam coef_t CORDIC_K = 32'sd652032874;

  // degrees in Q16
  localparam logic [31:0] DEG360 = 32'd23592960;
  localparam logic signed [25:0] A360 = 26'sd23592960;
  localparam logic signed [25:0] A180 = 26'sd11796480;
  localparam logic signed [25:0] A90  = 26'sd5898240;

  typedef struct packed {
    coef_t [8:0] m;    // upper-left 3x3, row-major
    coef_t [2:0] off;  // offset column of rows 0..2
    logic        eol;
  } op_t;

  typedef struct packed {
    coef_t b0;
    coef_t k1;
    coef_t k2;
  } term_t;

  typedef enum logic [2:0] {
    F_IDLE, F_REDUCE, F_FOLD, F_CORDIC, F_TERMS, F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE, B_MAC, B_DRAIN, B_EMIT
  } back_state_t;

  function automatic logic signed [25:0] atan_deg(input logic [3:0] i);
    logic signed [25:0] r;
    case (i)
      4'd0:  r = 26'sd2949120;
      4'd1:  r = 26'sd1740967;
      4'd2:  r = 26'sd919879;
      4'd3:  r = 26'sd466945;
      4'd4:  r = 26'sd234378;
      4'd5:  r = 26'sd117306;
      4'd6:  r = 26'sd58666;
      4'd7:  r = 26'sd29335;
      4'd8:  r = 26'sd14668;
      4'd9:  r = 26'sd7334;
      4'd10: r = 26'sd3667;
      4'd11: r = 26'sd1833;
      4'd12: r = 26'sd917;
      4'd13: r = 26'sd458;
      4'd14: r = 26'sd229;
      4'd15: r = 26'sd115;
      default: r = 26'sd0;
    endcase
    return r;
  endfunction

  // entry = b0 * 2^base + k1 * opa + k2 * opb
  function automatic term_t term_k(input logic [1:0] set, input logic [3:0] t);
    term_t r;
    coef_t ka, kb, kc, kd;
    ka = (set == SET_GRAY) ? K2126 : K213;
    kb = (set == SET_GRAY) ? K7874 : K787;
    kc = (set == SET_GRAY) ? K7152 : K715;
    kd = (set == SET_GRAY) ? K2848 : K285;
    r = '0;
    if (set == SET_HUE) begin
      case (t)
        4'd0: r = '{K213, K787, -K213};
        4'd1: r = '{K715, -K715, -K715};
        4'd2: r = '{K072, -K072, K928};
        4'd3: r = '{K213, -K213, K143};
        4'd4: r = '{K715, K285, K140};
        4'd5: r = '{K072, -K072, -K283};
        4'd6: r = '{K213, -K213, -K787};
        4'd7: r = '{K715, -K715, K715};
        4'd8: r = '{K072, K928, K072};
        default: r = '0;
      endcase
    end else begin
      case (t)
        4'd0: r = '{ka, kb, 32'sd0};
        4'd1: r = '{kc, -kc, 32'sd0};
        4'd2: r = '{Q30_ONE - ka - kc, kc - kb, 32'sd0};
        4'd3: r = '{ka, -ka, 32'sd0};
        4'd4: r = '{kc, kd, 32'sd0};
        4'd5: r = '{Q30_ONE - ka - kc, ka - kd, 32'sd0};
        4'd6: r = '{ka, -ka, 32'sd0};
        4'd7: r = '{kc, -kc, 32'sd0};
        4'd8: r = '{Q30_ONE - ka - kc, ka + kc, 32'sd0};
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  // round half up by sh bits, saturate to the coefficient width
  function automatic coef_t rnd_sat(input logic signed [ACC_W-1:0] v, input int sh);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] maxv;
    logic signed [ACC_W-1:0] minv;
    maxv = (ACC_W'(1) <<< (COEF_W - 1)) - ACC_W'(1);
    minv = -maxv - ACC_W'(1);
    t = (v + (ACC_W'(1) <<< (sh - 1))) >>> sh;
    if (t > maxv) return coef_t'(maxv);
    if (t < minv) return coef_t'(minv);
    return t[COEF_W-1:0];
  endfunction

endpackage
`default_nettype wire

### rtl/color_filter_matrix_composer_core.sv
// Color filter matrix composer: top level joining front, queue and back.
// Input channel (in_valid/in_stall) takes one filter operation per item:
// mode, a signed Q15.16 amount (degrees for hue rotate) and end_of_list.
// Output channel (out_valid/out_stall) gives the composed 4x5 matrix as four
// row items, row_index 0..3, with last_row set on row 3, Q15.16 coefficients.
// The front builds the operation matrix: identity, brightness, contrast and
// a zero hue amount go straight to the push state; grayscale and saturate
// take three multiply steps per coefficient; hue rotate adds an 8-step angle
// reduction and a 16-step CORDIC before the coefficient steps.
// The back multiplies the running matrix by that matrix on one shared
// multiplier, one product a cycle, 84 products per item; it takes the next
// item from the queue only once the last one is composed.
// A two-entry queue lets the front build the next item while the back works.
// On end_of_list the four rows follow the composition, one per cycle when
// not stalled; a stalled row holds and later rows wait. The running matrix
// then returns to identity.
// Reset clears the queue and state machines and sets the running matrix to
// identity; the block takes an item in the cycle after reset is released.
`default_nettype none
module color_filter_matrix_composer_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         mode,
  input  wire logic signed [31:0] amount,
  input  wire logic               end_of_list,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              row_index,
  output logic signed [31:0]      coef_r,
  output logic signed [31:0]      coef_g,
  output logic signed [31:0]      coef_b,
  output logic signed [31:0]      coef_a,
  output logic signed [31:0]      offset,
  output logic                    last_row
);
  logic          push, pop, q_full, q_nempty;
  cfmc_pkg::op_t op, q_head;

  cfmc_front u_front (
    .clk, .rst, .in_valid, .in_stall, .mode, .amount, .end_of_list,
    .q_full, .push, .op
  );

  cfmc_queue u_queue (
    .clk, .rst, .push, .op_in(op), .pop, .full(q_full), .nempty(q_nempty),
    .head(q_head)
  );

  cfmc_back u_back (
    .clk, .rst, .q_nempty, .q_head, .pop, .out_valid, .out_stall,
    .row_index, .coef_r, .coef_g, .coef_b, .coef_a, .offset, .last_row
  );
endmodule
`default_nettype wire

### rtl/cfmc_queue.sv
// Two-entry queue of built operation matrices between front and back.
`default_nettype none
module cfmc_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire cfmc_pkg::op_t op_in,
  input  wire logic          pop,
  output logic               full,
  output logic               nempty,
  output cfmc_pkg::op_t      head
);
  cfmc_pkg::op_t q [2];
  logic       wr;
  logic       rd;
  logic [1:0] count;

  assign full   = (count == 2'd2);
  assign nempty = (count != 2'd0);
  assign head   = q[rd];

  always_ff @(posedge clk) begin
    if (push) q[wr] <= op_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= 1'b0;
      rd    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr <= ~wr;
      if (pop) rd <= ~rd;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/cfmc_front.sv
// Front end: accepts filter items and builds each operation's matrix.
`default_nettype none
module cfmc_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [2:0]    mode,
  input  wire logic signed [31:0] amount,
  input  wire logic          end_of_list,
  input  wire logic          q_full,
  output logic               push,
  output cfmc_pkg::op_t      op
);
  cfmc_pkg::front_state_t state, state_next;

  logic [31:0]              rem;
  logic                     neg;
  logic [2:0]               kk;
  logic signed [33:0]       x, y;
  logic signed [25:0]       ang;
  logic                     flip;
  logic [3:0]               it;
  logic signed [34:0]       x1;
  logic [1:0]               tsel;
  logic [3:0]               t;
  logic [1:0]               ph;
  logic signed [66:0]       prod;
  logic signed [67:0]       acc;

  logic                     accept;
  logic                     hue_go;
  logic [32:0]              lim;
  logic signed [25:0]       r0, r1, r2;
  logic signed [34:0]       opa, opb;
  cfmc_pkg::term_t          tk;
  logic signed [67:0]       base;
  logic signed [33:0]       cdiff;
  logic signed [33:0]       chalf;
  cfmc_pkg::op_t            op_ld;

  assign accept = in_valid && !in_stall;
  assign hue_go = (mode == cfmc_pkg::MODE_HUE) && (amount != 32'sd0);
  assign lim    = 33'(cfmc_pkg::DEG360) << kk;
  assign cdiff  = 34'sd65536 - 34'(amount);
  assign chalf  = (cdiff + 34'sd1) >>> 1;

  always_comb begin
    r0 = neg ? -26'(rem) : 26'(rem);
    r1 = (r0 < 26'sd0) ? r0 + cfmc_pkg::A360 : r0;
    r2 = (r1 > cfmc_pkg::A180) ? r1 - cfmc_pkg::A360 : r1;
  end

  // matrix for the item being accepted; grayscale, saturate and hue fill in later
  always_comb begin
    op_ld      = '0;
    op_ld.eol  = end_of_list;
    op_ld.m[0] = cfmc_pkg::ONE;
    op_ld.m[4] = cfmc_pkg::ONE;
    op_ld.m[8] = cfmc_pkg::ONE;
    case (mode)
      cfmc_pkg::MODE_BRIGHT: begin
        op_ld.m[0] = amount;
        op_ld.m[4] = amount;
        op_ld.m[8] = amount;
      end
      cfmc_pkg::MODE_CONTRAST: begin
        op_ld.m[0]   = amount;
        op_ld.m[4]   = amount;
        op_ld.m[8]   = amount;
        op_ld.off[0] = chalf[31:0];
        op_ld.off[1] = chalf[31:0];
        op_ld.off[2] = chalf[31:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    if (tsel == cfmc_pkg::SET_HUE) begin
      opa = flip ? -35'(x) : 35'(x);
      opb = flip ? -35'(y) : 35'(y);
    end else begin
      opa = x1;
      opb = 35'sd0;
    end
    tk   = cfmc_pkg::term_k(tsel, t);
    base = (tsel == cfmc_pkg::SET_HUE) ? (68'(tk.b0) <<< 30) : (68'(tk.b0) <<< 16);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cfmc_pkg::F_IDLE: begin
        if (accept) begin
          if (hue_go) state_next = cfmc_pkg::F_REDUCE;
          else if (mode == cfmc_pkg::MODE_GRAY || mode == cfmc_pkg::MODE_SAT)
            state_next = cfmc_pkg::F_TERMS;
          else state_next = cfmc_pkg::F_PUSH;
        end
      end
      cfmc_pkg::F_REDUCE: if (kk == 3'd0) state_next = cfmc_pkg::F_FOLD;
      cfmc_pkg::F_FOLD:   state_next = cfmc_pkg::F_CORDIC;
      cfmc_pkg::F_CORDIC: if (it == 4'd15) state_next = cfmc_pkg::F_TERMS;
      cfmc_pkg::F_TERMS:  if (ph == 2'd2 && t == 4'd8) state_next = cfmc_pkg::F_PUSH;
      cfmc_pkg::F_PUSH:   if (!q_full) state_next = cfmc_pkg::F_IDLE;
      default:            state_next = cfmc_pkg::F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = (state != cfmc_pkg::F_IDLE);
    push     = (state == cfmc_pkg::F_PUSH) && !q_full;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= cfmc_pkg::F_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      cfmc_pkg::F_IDLE: begin
        if (accept) begin
          op  <= op_ld;
          t   <= 4'd0;
          ph  <= 2'd0;
          rem <= amount[31] ? 32'(-33'(amount)) : 32'(amount);
          neg <= amount[31];
          kk  <= 3'd7;
          case (mode)
            cfmc_pkg::MODE_GRAY: begin
              x1   <= 35'sd65536 - 35'(amount);
              tsel <= cfmc_pkg::SET_GRAY;
            end
            cfmc_pkg::MODE_SAT: begin
              x1   <= 35'(amount);
              tsel <= cfmc_pkg::SET_SAT;
            end
            cfmc_pkg::MODE_HUE: tsel <= cfmc_pkg::SET_HUE;
            default: ;
          endcase
        end
      end
      cfmc_pkg::F_REDUCE: begin
        if ({1'b0, rem} >= lim) rem <= rem - lim[31:0];
        kk <= kk - 3'd1;
      end
      cfmc_pkg::F_FOLD: begin
        x  <= 34'(cfmc_pkg::CORDIC_K);
        y  <= 34'sd0;
        it <= 4'd0;
        if (r2 > cfmc_pkg::A90) begin
          ang  <= r2 - cfmc_pkg::A180;
          flip <= 1'b1;
        end else if (r2 < -cfmc_pkg::A90) begin
          ang  <= r2 + cfmc_pkg::A180;
          flip <= 1'b1;
        end else begin
          ang  <= r2;
          flip <= 1'b0;
        end
      end
      cfmc_pkg::F_CORDIC: begin
        if (ang >= 26'sd0) begin
          x   <= x - (y >>> it);
          y   <= y + (x >>> it);
          ang <= ang - cfmc_pkg::atan_deg(it);
        end else begin
          x   <= x + (y >>> it);
          y   <= y - (x >>> it);
          ang <= ang + cfmc_pkg::atan_deg(it);
        end
        it <= it + 4'd1;
      end
      cfmc_pkg::F_TERMS: begin
        case (ph)
          2'd0: begin
            prod <= tk.k1 * opa;
            ph   <= 2'd1;
          end
          2'd1: begin
            acc  <= base + 68'(prod);
            prod <= tk.k2 * opb;
            ph   <= 2'd2;
          end
          default: begin
            op.m[t] <= (tsel == cfmc_pkg::SET_HUE) ?
                       cfmc_pkg::rnd_sat(acc + 68'(prod), 60 - cfmc_pkg::FRAC) :
                       cfmc_pkg::rnd_sat(acc + 68'(prod), 46 - cfmc_pkg::FRAC);
            t  <= t + 4'd1;
            ph <= 2'd0;
          end
        endcase
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### rtl/cfmc_back.sv
// Back end: composes the running matrix with each operation and emits rows.
`default_nettype none
module cfmc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_nempty,
  input  wire cfmc_pkg::op_t q_head,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         row_index,
  output logic signed [31:0] coef_r,
  output logic signed [31:0] coef_g,
  output logic signed [31:0] coef_b,
  output logic signed [31:0] coef_a,
  output logic signed [31:0] offset,
  output logic               last_row
);
  cfmc_pkg::back_state_t state, state_next;

  cfmc_pkg::coef_t    rm [4][5];
  cfmc_pkg::coef_t    rowbuf [4];
  cfmc_pkg::op_t      op;
  logic [1:0]         j;
  logic [2:0]         i;
  logic [2:0]         k;
  logic signed [63:0] prod;
  logic               pv, pf, pl;
  logic [2:0]         pi;
  logic [1:0]         pj;
  logic signed [67:0] acc;
  logic [1:0]         erow;

  logic [2:0]         klim;
  logic               mac_done;
  logic               load;
  cfmc_pkg::coef_t    bop;
  logic signed [67:0] sum;
  cfmc_pkg::coef_t    rv;

  assign klim     = (i == 3'd4) ? 3'd4 : 3'd3;
  assign mac_done = (j == 2'd3) && (i == 3'd4) && (k == klim);
  assign load     = (state == cfmc_pkg::B_EMIT) && (!out_valid || !out_stall);
  assign sum      = (pf ? 68'sd0 : acc) + 68'(prod);
  assign rv       = cfmc_pkg::rnd_sat(sum, cfmc_pkg::FRAC);

  // column i of the operation matrix, row k
  always_comb begin
    bop = '0;
    if (k < 3'd3) begin
      if (i < 3'd3) bop = op.m[4'(k) * 4'd3 + 4'(i)];
      else if (i == 3'd4) bop = op.off[k[1:0]];
    end else if (k == 3'd3) begin
      if (i == 3'd3) bop = cfmc_pkg::ONE;
    end else begin
      bop = cfmc_pkg::ONE;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cfmc_pkg::B_IDLE:  if (q_nempty) state_next = cfmc_pkg::B_MAC;
      cfmc_pkg::B_MAC:   if (mac_done) state_next = cfmc_pkg::B_DRAIN;
      cfmc_pkg::B_DRAIN: state_next = op.eol ? cfmc_pkg::B_EMIT : cfmc_pkg::B_IDLE;
      cfmc_pkg::B_EMIT:  if (load && erow == 2'd3) state_next = cfmc_pkg::B_IDLE;
      default:           state_next = cfmc_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop = (state == cfmc_pkg::B_IDLE) && q_nempty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cfmc_pkg::B_IDLE;
      pv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pv    <= (state == cfmc_pkg::B_MAC);
      if (load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op <= q_head;
      j  <= 2'd0;
      i  <= 3'd0;
      k  <= 3'd0;
    end
    if (state == cfmc_pkg::B_MAC) begin
      prod <= rm[j][k] * bop;
      pf   <= (k == 3'd0);
      pl   <= (k == klim);
      pi   <= i;
      pj   <= j;
      if (k == klim) begin
        k <= 3'd0;
        if (i == 3'd4) begin
          i <= 3'd0;
          j <= j + 2'd1;
        end else begin
          i <= i + 3'd1;
        end
      end else begin
        k <= k + 3'd1;
      end
    end
    if (pv) begin
      acc <= sum;
      if (pl) begin
        if (pi == 3'd4) begin
          rm[pj][0] <= rowbuf[0];
          rm[pj][1] <= rowbuf[1];
          rm[pj][2] <= rowbuf[2];
          rm[pj][3] <= rowbuf[3];
          rm[pj][4] <= rv;
        end else begin
          rowbuf[pi[1:0]] <= rv;
        end
      end
    end
    if (state == cfmc_pkg::B_DRAIN) erow <= 2'd0;
    if (load) begin
      row_index <= erow;
      coef_r    <= rm[erow][0];
      coef_g    <= rm[erow][1];
      coef_b    <= rm[erow][2];
      coef_a    <= rm[erow][3];
      offset    <= rm[erow][4];
      last_row  <= (erow == 2'd3);
      erow      <= erow + 2'd1;
    end
    // return to identity on reset and once the last row is out
    if (rst || (load && erow == 2'd3)) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 5; c++) begin
          rm[r][c] <= (r == c) ? cfmc_pkg::ONE : '0;
        end
      end
    end
  end
endmodule
`default_nettype wire
